// File: sv/mvla_pkg.sv
package mvla_pkg;

   localparam int SITE_BITS       = 10;
   localparam int AREA_BITS       = 21;
   localparam int MAX_SITES_DEF   = 64;
   localparam int COORD_BITS_DEF  = 10;
   localparam int NUM_FLAGS       = 4;

   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_UP    = 1;
   localparam int FLAG_RIGHT = 2;
   localparam int FLAG_DOWN  = 3;

   localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

   typedef struct packed {
      logic load;
      logic rot;
      logic wrap;
      logic probe;
      logic clr;
   } cell_ctl_type;

endpackage

// File: sv/mvla_if.sv
interface mvla_req_if;
   logic                           valid;
   logic                           ready;
   logic [mvla_pkg::SITE_BITS-1:0] site_x;
   logic [mvla_pkg::SITE_BITS-1:0] site_y;
   logic                           last_site;

   modport source (output valid, output site_x, output site_y, output last_site, input ready);
   modport sink   (input valid, input site_x, input site_y, input last_site, output ready);
endinterface

interface mvla_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mvla_pkg::AREA_BITS-1:0] peak_area;

   modport source (output valid, output peak_area, input ready);
   modport sink   (input valid, input peak_area, output ready);
endinterface

// File: sv/mvla_cell.sv
module mvla_cell #(
   parameter int COORD_BITS = mvla_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  mvla_pkg::cell_ctl_type          ctl,
   input  logic [COORD_BITS-1:0]           ld_x,
   input  logic [COORD_BITS-1:0]           ld_y,
   input  logic [COORD_BITS-1:0]           probe_x,
   input  logic [COORD_BITS-1:0]           probe_y,
   input  logic [COORD_BITS-1:0]           nb_x,
   input  logic [COORD_BITS-1:0]           nb_y,
   input  logic [mvla_pkg::NUM_FLAGS-1:0]  nb_flags,
   input  logic [mvla_pkg::AREA_BITS-1:0]  nb_area,
   input  logic [COORD_BITS-1:0]           wr_x,
   input  logic [COORD_BITS-1:0]           wr_y,
   input  logic [mvla_pkg::NUM_FLAGS-1:0]  wr_flags,
   input  logic [mvla_pkg::AREA_BITS-1:0]  wr_area,
   output logic [COORD_BITS-1:0]           out_x,
   output logic [COORD_BITS-1:0]           out_y,
   output logic [mvla_pkg::NUM_FLAGS-1:0]  out_flags,
   output logic [mvla_pkg::AREA_BITS-1:0]  out_area
);
   import mvla_pkg::*;

   logic [COORD_BITS-1:0] x_ff, y_ff, x_in, y_in;
   logic [NUM_FLAGS-1:0]  flags_ff, flags_in;
   logic [AREA_BITS-1:0]  area_ff, area_in;
   logic [COORD_BITS-1:0] dx, dy;
   logic [NUM_FLAGS-1:0]  cone;

   assign dx = (probe_x > x_ff) ? probe_x - x_ff : x_ff - probe_x;
   assign dy = (probe_y > y_ff) ? probe_y - y_ff : y_ff - probe_y;

   always_comb begin
      cone             = '0;
      cone[FLAG_LEFT]  = (probe_x < x_ff) && (dx >= dy);
      cone[FLAG_UP]    = (probe_y > y_ff) && (dy >= dx);
      cone[FLAG_RIGHT] = (probe_x > x_ff) && (dx >= dy);
      cone[FLAG_DOWN]  = (probe_y < y_ff) && (dy >= dx);
   end

   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_flags = ctl.probe ? (flags_ff | cone) : flags_ff;
   assign out_area  = ctl.clr ? '0 : area_ff;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      flags_in = flags_ff;
      area_in  = area_ff;
      if (ctl.load) begin
         x_in     = ld_x;
         y_in     = ld_y;
         flags_in = '0;
         area_in  = '0;
      end else if (ctl.rot) begin
         if (ctl.wrap) begin
            x_in     = wr_x;
            y_in     = wr_y;
            flags_in = wr_flags;
            area_in  = wr_area;
         end else begin
            x_in     = nb_x;
            y_in     = nb_y;
            flags_in = nb_flags;
            area_in  = nb_area;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      flags_ff <= flags_in;
      area_ff  <= area_in;
   end

endmodule

// File: sv/manhattan_voronoi_largest_area.sv
// phases: cone test, grid scan over every point (x, y) with x in 0..X and y in 0..Y,
// final pass (X and Y the largest coordinates); the result follows in the next cycle
// throughput: one site per cycle while loading; the scan visits the held sites at each grid point
// while busy the site ring rotates once per cycle past a single distance unit at its head
// reset: synchronous, active high; clears site count, extents and control state
module manhattan_voronoi_largest_area #(
   parameter int MAX_SITES  = mvla_pkg::MAX_SITES_DEF,
   parameter int COORD_BITS = mvla_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mvla_req_if.sink   req_chan,
   mvla_rsp_if.source rsp_chan
);
   import mvla_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_SITES + 1);
   localparam int DIST_BITS = COORD_BITS + 1;

   typedef enum logic [2:0] {IDLE, BOUND, SCAN, FINAL, DONE} state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in, step_ff, step_in;
   logic [CNT_BITS-1:0]   owner_ff, owner_in, pend_owner_ff, pend_owner_in;
   logic [COORD_BITS-1:0] ext_x_ff, ext_x_in, ext_y_ff, ext_y_in;
   logic [COORD_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [DIST_BITS-1:0]  bestd_ff, bestd_in;
   logic                  owned_ff, owned_in, pend_valid_ff, pend_valid_in;
   logic                  pend_owned_ff, pend_owned_in;
   logic [AREA_BITS-1:0]  best_ff, best_in;

   logic [COORD_BITS-1:0] cx [MAX_SITES];
   logic [COORD_BITS-1:0] cy [MAX_SITES];
   logic [NUM_FLAGS-1:0]  cf [MAX_SITES];
   logic [AREA_BITS-1:0]  ca [MAX_SITES];

   logic [COORD_BITS-1:0] in_x, in_y;
   logic                  accept, store, last_step, inc, rotating;
   logic [CNT_BITS-1:0]   count_m1;
   logic [COORD_BITS-1:0] adx, ady;
   logic [DIST_BITS-1:0]  head_dist;
   logic [AREA_BITS:0]    head_sum;
   logic [AREA_BITS-1:0]  head_area;

   assign in_x     = COORD_BITS'(req_chan.site_x);
   assign in_y     = COORD_BITS'(req_chan.site_y);
   assign accept   = req_chan.valid && req_chan.ready;
   assign store    = accept && (count_ff < CNT_BITS'(MAX_SITES));
   assign count_m1 = count_ff - CNT_BITS'(1);
   assign last_step = (step_ff == count_m1);
   assign rotating = (state_ff == BOUND) || (state_ff == SCAN) || (state_ff == FINAL);

   assign req_chan.ready     = (state_ff == IDLE);
   assign rsp_chan.valid     = (state_ff == DONE);
   assign rsp_chan.peak_area = best_ff;

   assign adx       = (gx_ff > cx[0]) ? gx_ff - cx[0] : cx[0] - gx_ff;
   assign ady       = (gy_ff > cy[0]) ? gy_ff - cy[0] : cy[0] - gy_ff;
   assign head_dist = DIST_BITS'(adx) + DIST_BITS'(ady);

   assign inc       = pend_valid_ff && pend_owned_ff && (pend_owner_ff == step_ff);
   assign head_sum  = {1'b0, ca[0]} + (AREA_BITS + 1)'(inc);
   assign head_area = head_sum[AREA_BITS] ? AREA_MAX : head_sum[AREA_BITS-1:0];

   for (genvar i = 0; i < MAX_SITES; i++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.load  = store && (count_ff == CNT_BITS'(i));
      assign ctl.rot   = rotating;
      assign ctl.wrap  = (count_m1 == CNT_BITS'(i));
      assign ctl.probe = (state_ff == BOUND);
      assign ctl.clr   = (state_ff == BOUND);

      mvla_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .ld_x     (in_x),
         .ld_y     (in_y),
         .probe_x  (cx[0]),
         .probe_y  (cy[0]),
         .nb_x     (cx[(i + 1) % MAX_SITES]),
         .nb_y     (cy[(i + 1) % MAX_SITES]),
         .nb_flags (cf[(i + 1) % MAX_SITES]),
         .nb_area  (ca[(i + 1) % MAX_SITES]),
         .wr_x     (cx[0]),
         .wr_y     (cy[0]),
         .wr_flags (cf[0]),
         .wr_area  (head_area),
         .out_x    (cx[i]),
         .out_y    (cy[i]),
         .out_flags(cf[i]),
         .out_area (ca[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ext_x_in      = ext_x_ff;
      ext_y_in      = ext_y_ff;
      step_in       = step_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      bestd_in      = bestd_ff;
      owner_in      = owner_ff;
      owned_in      = owned_ff;
      pend_valid_in = pend_valid_ff;
      pend_owner_in = pend_owner_ff;
      pend_owned_in = pend_owned_ff;
      best_in       = best_ff;
      unique case (state_ff)
         IDLE: begin
            if (store) begin
               count_in = count_ff + CNT_BITS'(1);
               if (in_x > ext_x_ff) ext_x_in = in_x;
               if (in_y > ext_y_ff) ext_y_in = in_y;
            end
            if (accept && req_chan.last_site) begin
               step_in       = '0;
               pend_valid_in = 1'b0;
               state_in      = BOUND;
            end
         end
         BOUND: begin
            step_in = step_ff + CNT_BITS'(1);
            if (last_step) begin
               step_in       = '0;
               gx_in         = '0;
               gy_in         = '0;
               pend_valid_in = 1'b0;
               state_in      = SCAN;
            end
         end
         SCAN: begin
            if ((step_ff == '0) || (head_dist < bestd_ff)) begin
               bestd_in = head_dist;
               owner_in = step_ff;
               owned_in = 1'b1;
            end else if (head_dist == bestd_ff) begin
               owned_in = 1'b0;
            end
            step_in = step_ff + CNT_BITS'(1);
            if (last_step) begin
               step_in       = '0;
               pend_valid_in = 1'b1;
               pend_owner_in = owner_in;
               pend_owned_in = owned_in;
               if (gy_ff == ext_y_ff) begin
                  gy_in = '0;
                  if (gx_ff == ext_x_ff) begin
                     best_in  = '0;
                     state_in = FINAL;
                  end else begin
                     gx_in = gx_ff + COORD_BITS'(1);
                  end
               end else begin
                  gy_in = gy_ff + COORD_BITS'(1);
               end
            end
         end
         FINAL: begin
            if ((&cf[0]) && (head_area > best_ff)) best_in = head_area;
            step_in = step_ff + CNT_BITS'(1);
            if (last_step) begin
               step_in  = '0;
               state_in = DONE;
            end
         end
         DONE: begin
            if (rsp_chan.ready) begin
               count_in = '0;
               ext_x_in = '0;
               ext_y_in = '0;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         ext_x_ff      <= '0;
         ext_y_ff      <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ext_x_ff      <= ext_x_in;
         ext_y_ff      <= ext_y_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
      end
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      bestd_ff      <= bestd_in;
      owner_ff      <= owner_in;
      owned_ff      <= owned_in;
      pend_owner_ff <= pend_owner_in;
      pend_owned_ff <= pend_owned_in;
      best_ff       <= best_in;
   end

endmodule

// File: sv/mvla_check.sv
module mvla_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready
);

   // result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction");

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("site taken while result pending");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready && !rsp_valid)
      else $error("batch end did not start computation");

endmodule

bind manhattan_voronoi_largest_area mvla_check u_mvla_check (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_last (req_chan.last_site),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready)
);

// File: tb/tb.sv
module tb;
   import mvla_pkg::*;

   typedef struct packed {
      logic [SITE_BITS-1:0] x;
      logic [SITE_BITS-1:0] y;
      logic                 last;
   } site_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mvla_req_if req_chan ();
   mvla_rsp_if rsp_chan ();

   manhattan_voronoi_largest_area u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #1 clock = ~clock;

   site_item_type          site_queue[$];
   logic [AREA_BITS-1:0]   area_expected[$];
   logic [SITE_BITS-1:0]   held_x[$];
   logic [SITE_BITS-1:0]   held_y[$];
   logic                   req_took = 1'b0;
   logic                   quiet = 1'b0;
   logic                   stim_done = 1'b0;
   int                     req_gap = 0;
   int                     rsp_gap = 0;
   int                     errors = 0;

   function automatic int adiff(int a, int b);
      return a > b ? a - b : b - a;
   endfunction

   // largest owned area among sites boxed in on all four diagonal cones
   function automatic logic [AREA_BITS-1:0] largest_bounded_area();
      int n, ex, ey, best, bestd, owner, md, dx, dy;
      bit l, u, r, d, have, owned;
      bit bounded[MAX_SITES_DEF];
      int area[MAX_SITES_DEF];
      n = held_x.size();
      ex = 0;
      ey = 0;
      best = 0;
      for (int s = 0; s < n; s++) begin
         l = 0; u = 0; r = 0; d = 0;
         if (held_x[s] > ex) ex = held_x[s];
         if (held_y[s] > ey) ey = held_y[s];
         for (int t = 0; t < n; t++) begin
            dx = adiff(held_x[t], held_x[s]);
            dy = adiff(held_y[t], held_y[s]);
            if (held_x[t] < held_x[s] && dx >= dy) l = 1;
            if (held_y[t] > held_y[s] && dy >= dx) u = 1;
            if (held_x[t] > held_x[s] && dx >= dy) r = 1;
            if (held_y[t] < held_y[s] && dy >= dx) d = 1;
         end
         bounded[s] = l && u && r && d;
         area[s] = 0;
      end
      for (int cx = 0; cx <= ex; cx++) begin
         for (int cy = 0; cy <= ey; cy++) begin
            have = 0;
            owned = 0;
            bestd = 0;
            owner = 0;
            for (int t = 0; t < n; t++) begin
               md = adiff(cx, held_x[t]) + adiff(cy, held_y[t]);
               if (!have || md < bestd) begin
                  have = 1;
                  bestd = md;
                  owner = t;
                  owned = 1;
               end else if (md == bestd) begin
                  owned = 0;
               end
            end
            if (owned) area[owner]++;
         end
      end
      for (int s = 0; s < n; s++)
         if (bounded[s] && area[s] > best) best = area[s];
      if (best > AREA_MAX) best = AREA_MAX;
      return best[AREA_BITS-1:0];
   endfunction

   task automatic add_site(int x, int y, bit last);
      site_item_type it;
      it.x = SITE_BITS'(x);
      it.y = SITE_BITS'(y);
      it.last = last;
      site_queue = {site_queue, it};
   endtask

   task automatic add_batch(int n, int span);
      for (int i = 0; i < n; i++)
         add_site($urandom_range(span), $urandom_range(span), i == n - 1);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.site_x <= '0;
         req_chan.site_y <= '0;
         req_chan.last_site <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || req_took) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (!quiet && $urandom_range(9) == 0) begin
               req_gap <= $urandom_range(11, 1) - 1;
               req_chan.valid <= 1'b0;
            end else if (site_queue.size() > 0) begin
               site_item_type it;
               it = site_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.site_x <= it.x;
               req_chan.site_y <= it.y;
               req_chan.last_site <= it.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(7) == 0) begin
            rsp_gap <= $urandom_range(11, 1) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      req_took <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (held_x.size() < MAX_SITES_DEF) begin
               held_x = {held_x, req_chan.site_x};
               held_y = {held_y, req_chan.site_y};
            end
            if (req_chan.last_site) begin
               area_expected = {area_expected, largest_bounded_area()};
               held_x.delete();
               held_y.delete();
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (area_expected.size() == 0) begin
               $display("%0t: unexpected transaction, peak_area expected none actual %0d",
                        $time, rsp_chan.peak_area);
               errors++;
            end else begin
               logic [AREA_BITS-1:0] want;
               want = area_expected.pop_front();
               if (rsp_chan.peak_area !== want) begin
                  $display("%0t: peak_area expected %0d actual %0d",
                           $time, want, rsp_chan.peak_area);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int span, n;
      // single site, origin
      add_site(0, 0, 1);
      // center boxed in by four neighbors
      add_site(2, 2, 0); add_site(0, 2, 0); add_site(2, 4, 0);
      add_site(4, 2, 0); add_site(2, 0, 1);
      // neighbors exactly on cone edges, plus ties
      add_site(3, 3, 0); add_site(0, 0, 0); add_site(0, 6, 0);
      add_site(6, 6, 0); add_site(6, 0, 1);
      // extreme coordinates with one thin axis
      add_site(1023, 0, 0); add_site(0, 1, 1);
      add_site(0, 1023, 1);
      add_site(682, 1, 0); add_site(341, 0, 1);
      add_site(1, 682, 0); add_site(0, 341, 1);
      // store full: extra sites dropped, last still runs
      for (int i = 0; i < MAX_SITES_DEF + 3; i++)
         add_site($urandom_range(3), $urandom_range(3), i == MAX_SITES_DEF + 2);
      n = 0;
      while (n < 1750) begin
         if ($urandom_range(49) == 0) begin
            if ($urandom_range(1)) add_site($urandom_range(1023), $urandom_range(1), 1);
            else add_site($urandom_range(1), $urandom_range(1023), 1);
            n++;
         end else begin
            span = $urandom_range(18, 2);
            begin
               int k;
               k = $urandom_range(10, 1);
               add_batch(k, span);
               n += k;
            end
         end
      end
      add_site(5, 5, 1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (site_queue.size() > 200) @(posedge clock);
      quiet <= 1'b1;
      while (site_queue.size() > 0 || req_chan.valid) @(posedge clock);
      while (area_expected.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: manhattan_voronoi_largest_area.f
sv/mvla_pkg.sv
sv/mvla_if.sv
sv/mvla_cell.sv
sv/manhattan_voronoi_largest_area.sv
sv/mvla_check.sv
tb/tb.sv
